// ----- hdl/codebook_3bit_key_dot_product_assert.svh -----
// assertion macros for the codebook key dot product block
// expects clk_i and rst_ni in the scope where the macros are used
`ifndef CODEBOOK_3BIT_KEY_DOT_PRODUCT_ASSERT_SVH
`define CODEBOOK_3BIT_KEY_DOT_PRODUCT_ASSERT_SVH

// same-cycle implication
`define CBKDP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CBKDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/cbkdp_pkg.sv -----
// constants and widths for the codebook key dot product block
// no dependencies
package cbkdp_pkg;

  localparam int MaxDim   = 256;
  localparam int NumLevel = 8;
  localparam int IdxBits  = 3;
  localparam int PerWord  = 8;
  localparam int Rows     = MaxDim / PerWord;
  localparam int RowW     = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int PosW     = RowW + 1;
  localparam int LaneW    = $clog2(PerWord);

  localparam int CmdW     = 1;
  localparam int QIdxW    = 8;
  localparam int QValW    = 16;
  localparam int KeyW     = IdxBits * PerWord;
  localparam int NormW    = 16;
  localparam int CentW    = 16;
  localparam int CfgIdxW  = $clog2(NumLevel);
  localparam int CfgDataW = 16;
  localparam int ScoreW   = 32;

  localparam int ProdW    = QValW + CentW;
  localparam int SumW     = ProdW + LaneW;
  localparam int AccW     = 40;
  localparam int HalfW    = AccW / 2;
  localparam int FullW    = AccW + NormW + 1;
  localparam int RndShift = 16;

  localparam logic [CmdW-1:0] CmdQuery = 1'b0;
  localparam logic [CmdW-1:0] CmdKey   = 1'b1;

endpackage

// ----- hdl/codebook_3bit_key_dot_product.sv -----
// codebook key dot product: query store in lane memories, centroid decode,
// accumulate and norm-scaled Q16.16 score. uses cbkdp_pkg and the assert header
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------
//  in      | sink      | in_valid_i / in_stall_o | cmd, query_index/value, key word
//  out     | source    | out_valid_o/out_stall_i | score_o, overrun_o
//  cfg     | sink      | cfg_we_i                | cfg_index_i, cfg_data_i
//
// a query beat is written to its lane memory; a key beat passes lane memory
// read, 8 multipliers, adder tree and accumulate, stalling the input; a last key
// beat adds scaling and rounding and waits while out_stall_i holds the result.
// the query store is 8 lane memories of MaxDim/8 rows, no clearing pass.
// reset clears the sequencer, accumulator, word count, overflow and out-valid flags and centroids.
`include "codebook_3bit_key_dot_product_assert.svh"

module codebook_3bit_key_dot_product (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [cbkdp_pkg::CmdW-1:0]             cmd_i,
  input  logic [cbkdp_pkg::QIdxW-1:0]            query_index_i,
  input  logic signed [cbkdp_pkg::QValW-1:0]     query_value_i,
  input  logic [cbkdp_pkg::KeyW-1:0]             key_word_i,
  input  logic [cbkdp_pkg::NormW-1:0]            key_norm_i,
  input  logic                                   last_word_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [cbkdp_pkg::ScoreW-1:0]    score_o,
  output logic                                   overrun_o,
  input  logic                                   cfg_we_i,
  input  logic [cbkdp_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [cbkdp_pkg::CfgDataW-1:0]         cfg_data_i
);
  import cbkdp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_SCL  = 3'd4;
  localparam logic [2:0] S_RND  = 3'd5;

  localparam int ExtW = (QIdxW > LaneW + RowW) ? QIdxW : LaneW + RowW;

  localparam logic signed [AccW:0] AccMax = {2'b00, {(AccW-1){1'b1}}};
  localparam logic signed [AccW:0] AccMin = {2'b11, {(AccW-1){1'b0}}};
  localparam logic signed [FullW-RndShift-1:0] ScoreMax =
    (FullW-RndShift)'({1'b0, {(ScoreW-1){1'b1}}});
  localparam logic signed [FullW-RndShift-1:0] ScoreMin =
    (FullW-RndShift)'($signed({1'b1, {(ScoreW-1){1'b0}}}));

  logic [2:0]                     state_q, state_d;
  logic signed [CentW-1:0]        cent_q [NumLevel];
  logic signed [QValW-1:0]        rd_q   [PerWord];
  logic signed [ProdW-1:0]        prod_q [PerWord];
  logic signed [SumW-1:0]         sum_q;
  logic signed [AccW-1:0]         acc_q, acc_d;
  logic [PosW-1:0]                pos_q, pos_d;
  logic                           ovf_q, ovf_d;
  logic [KeyW-1:0]                kw_q;
  logic [NormW-1:0]               norm_q;
  logic                           last_q;
  logic                           fits_q;
  logic signed [HalfW+NormW:0]    phi_q;
  logic [HalfW+NormW-1:0]         plo_q;
  logic                           out_valid_q;
  logic signed [ScoreW-1:0]       score_q;
  logic                           overrun_q;

  logic                           in_acc;
  logic                           q_wr;
  logic [ExtW-1:0]                qidx_ext;
  logic [LaneW-1:0]               wr_lane;
  logic [RowW-1:0]                wr_row;
  logic [RowW-1:0]                rd_row;
  logic                           rd_en;
  logic                           out_load;
  logic signed [SumW-1:0]         tree_sum;
  logic signed [AccW:0]           acc_sum;
  logic signed [FullW-1:0]        full_prod;
  logic signed [FullW-1:0]        full_rnd;
  logic signed [FullW-RndShift-1:0] shifted;
  logic signed [ScoreW-1:0]       score_sat;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign qidx_ext = ExtW'(query_index_i);
  assign wr_lane  = qidx_ext[LaneW-1:0];
  assign wr_row   = qidx_ext[LaneW +: RowW];
  assign q_wr     = in_acc && (cmd_i == CmdQuery) && (32'(query_index_i) < 32'(MaxDim));
  assign rd_en    = in_acc && (cmd_i == CmdKey);
  assign rd_row   = pos_q[RowW-1:0];

  // one memory per lane, lane l holds query elements 8k+l
  for (genvar l = 0; l < PerWord; l++) begin : g_lane
    logic signed [QValW-1:0] lane_mem [Rows];

    always_ff @(posedge clk_i) begin
      if (q_wr && (wr_lane == LaneW'(l))) begin
        lane_mem[wr_row] <= query_value_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rd_en) begin
        rd_q[l] <= lane_mem[rd_row];
      end
    end

    always_ff @(posedge clk_i) begin
      if (state_q == S_MUL) begin
        prod_q[l] <= rd_q[l] * cent_q[kw_q[IdxBits*l +: IdxBits]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLevel; i++) begin
        cent_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      cent_q[cfg_index_i] <= cfg_data_i;
    end
  end

  always_comb begin
    tree_sum = '0;
    for (int i = 0; i < PerWord; i++) begin
      tree_sum = tree_sum + SumW'(prod_q[i]);
    end
  end

  always_comb begin
    acc_sum = (AccW+1)'(acc_q) + (AccW+1)'(sum_q);
  end

  // acc * norm as two 20x16 partial products, recombined before rounding
  always_comb begin
    full_prod = (FullW'(phi_q) <<< HalfW) + FullW'(plo_q);
    full_rnd  = full_prod + FullW'(1 << (RndShift - 1));
    shifted   = full_rnd[FullW-1:RndShift];
    if (shifted > ScoreMax) begin
      score_sat = ScoreMax[ScoreW-1:0];
    end else if (shifted < ScoreMin) begin
      score_sat = ScoreMin[ScoreW-1:0];
    end else begin
      score_sat = shifted[ScoreW-1:0];
    end
  end

  assign out_load = (state_q == S_RND) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    pos_d   = pos_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      S_IDLE: begin
        if (rd_en) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_SUM;
      end
      S_SUM: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        if (fits_q) begin
          if (acc_sum > AccMax) begin
            acc_d = AccMax[AccW-1:0];
          end else if (acc_sum < AccMin) begin
            acc_d = AccMin[AccW-1:0];
          end else begin
            acc_d = acc_sum[AccW-1:0];
          end
          pos_d = pos_q + PosW'(1);
        end else begin
          ovf_d = 1'b1;
        end
        state_d = last_q ? S_SCL : S_IDLE;
      end
      S_SCL: begin
        state_d = S_RND;
      end
      S_RND: begin
        if (out_load) begin
          acc_d   = '0;
          pos_d   = '0;
          ovf_d   = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= '0;
      pos_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      pos_q       <= pos_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      kw_q   <= key_word_i;
      norm_q <= key_norm_i;
      last_q <= last_word_i;
      fits_q <= (pos_q < PosW'(Rows));
    end
    if (state_q == S_SUM) begin
      sum_q <= tree_sum;
    end
    if (state_q == S_SCL) begin
      phi_q <= $signed(acc_q[AccW-1:HalfW]) * $signed({1'b0, norm_q});
      plo_q <= acc_q[HalfW-1:0] * norm_q;
    end
    if (out_load) begin
      score_q   <= score_sat;
      overrun_q <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign score_o     = score_q;
  assign overrun_o   = overrun_q;

  `CBKDP_ASSERT_NOW(a_pos_range, 1'b1, pos_q <= PosW'(Rows),
    "word count ran past the query store")
  `CBKDP_ASSERT_NEXT(a_token_clear, out_load, (acc_q == '0) && (pos_q == '0) && !ovf_q,
    "token state not cleared after score")
  `CBKDP_ASSERT_NOW(a_out_source, out_valid_o && !$past(out_valid_o),
    $past(state_q) == S_RND, "result appeared outside the rounding step")

endmodule
